// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used across the design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dwg_pkg.sv =====
// ----------------------------------------------------------------------------
// dwg_pkg
// Types, codes and helpers shared by the damped wave grid step block.
// ----------------------------------------------------------------------------
package dwg_pkg;

    localparam int GRID_SIDE_DEF    = 32;
    localparam int MAX_SUBSTEPS_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;
    localparam int THR_W      = 26;

    localparam logic [CFG_IDX_W-1:0] REG_WAVE_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLEEP_THR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NONE       = 2'd3;

    localparam logic [15:0]      WAVE_COEF_RST = 16'd16384;
    localparam logic [15:0]      DAMPING_RST   = 16'd65209;
    localparam logic [THR_W-1:0] SLEEP_THR_RST = 26'd41;
    localparam logic [16:0]      COEF_MAX      = 17'd32768;

    localparam logic [1:0] KIND_DEPOSIT = 2'd0;
    localparam logic [1:0] KIND_STEP    = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;
    localparam logic [1:0] KIND_NONE    = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         cell_x;
        logic [4:0]         cell_z;
        logic signed [15:0] add_height;
        logic signed [15:0] add_previous;
        logic [3:0]         step_count;
    } t_item;

    typedef struct packed {
        logic signed [15:0] height;
        logic               asleep;
    } t_result;

    typedef struct packed {
        logic [16:0]      wave_coef;
        logic [15:0]      damping;
        logic [THR_W-1:0] sleep_thr;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_DEPOSIT,
        OP_STEP,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [4:0]         cell_x;
        logic [4:0]         cell_z;
        logic signed [15:0] add_height;
        logic signed [15:0] add_previous;
        logic [3:0]         steps;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEP,
        ST_RD,
        ST_SWEEP,
        ST_MUL1,
        ST_ADD,
        ST_MUL2,
        ST_WR,
        ST_SUM,
        ST_CMP,
        ST_DONE
    } t_eng_state;

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        logic signed [15:0] r;
        if (v > 24'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -24'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== design/damped_wave_grid_step.sv =====
// Step items are paced by the single-port read of the current bank
// (6 reads per cell) and the two multiplies.
// Falling asleep adds a clearing pass over both banks.
// After reset a clearing pass runs with full high.
// Synchronous active-low reset; configuration resets to its default values.
// ----------------------------------------------------------------------------
// damped_wave_grid_step
// Damped 2D wave field on a square grid with deposit, step and read items.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module damped_wave_grid_step import dwg_pkg::*; #(
    parameter int GRID_SIDE    = GRID_SIDE_DEF,
    parameter int MAX_SUBSTEPS = MAX_SUBSTEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_item                 i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0]      r_wave_coef;
    logic [15:0]      r_damping;
    logic [THR_W-1:0] r_sleep_thr;
    t_cfg             cfg;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             cmd_pop;
    logic             init_clear;
    logic             out_valid;

    assign o_cfg_ready   = 1'b1;
    assign cfg.wave_coef = ({1'b0, r_wave_coef} > COEF_MAX) ? COEF_MAX : {1'b0, r_wave_coef};
    assign cfg.damping   = r_damping;
    assign cfg.sleep_thr = r_sleep_thr;
    assign empty         = !out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_coef <= WAVE_COEF_RST;
            r_damping   <= DAMPING_RST;
            r_sleep_thr <= SLEEP_THR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WAVE_COEF: r_wave_coef <= i_cfg_data[15:0];
                REG_DAMPING:   r_damping   <= i_cfg_data[15:0];
                REG_SLEEP_THR: r_sleep_thr <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    dwg_front #(
        .GRID_SIDE   (GRID_SIDE),
        .MAX_SUBSTEPS(MAX_SUBSTEPS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .i_hold     (init_clear),
        .o_full     (full),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    dwg_engine #(
        .GRID_SIDE(GRID_SIDE)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_init_clear(init_clear),
        .o_out_valid (out_valid),
        .o_out       (o_result),
        .i_out_pop   (pop)
    );

    `ASSERT_IMPLY(a_full_in_init, i_clk, i_rst_n, init_clear, full, "full low during init clear")
    `ASSERT_IMPLY(a_full_has_cmd, i_clk, i_rst_n, full && !init_clear, cmd_valid, "queue full but no command")
    `ASSERT_IMPLY(a_asleep_zero, i_clk, i_rst_n, !empty && o_result.asleep, o_result.height == 16'sd0, "nonzero height while asleep")
    `ASSERT_NEXT(a_pop_no_cmd_in_init, i_clk, i_rst_n, init_clear, !cmd_pop || !init_clear, "command taken during init clear")

endmodule

// ===== design/dwg_front.sv =====
// ----------------------------------------------------------------------------
// dwg_front
// Accepts items, classifies them into commands and queues them for the engine.
// ----------------------------------------------------------------------------
module dwg_front import dwg_pkg::*; #(
    parameter int GRID_SIDE    = GRID_SIDE_DEF,
    parameter int MAX_SUBSTEPS = MAX_SUBSTEPS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_hold,
    output logic  o_full,
    output logic  o_cmd_valid,
    output t_cmd  o_cmd,
    input  logic  i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    t_cmd       cmd_in;
    logic       in_grid;
    logic       accept;
    logic       take;

    assign o_full      = (r_cnt == 2'd2) || i_hold;
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign take        = i_cmd_pop && o_cmd_valid;

    always_comb begin
        in_grid             = (32'(i_item.cell_x) < GRID_SIDE) &&
                              (32'(i_item.cell_z) < GRID_SIDE);
        cmd_in.op           = OP_NOP;
        cmd_in.cell_x       = i_item.cell_x;
        cmd_in.cell_z       = i_item.cell_z;
        cmd_in.add_height   = i_item.add_height;
        cmd_in.add_previous = i_item.add_previous;
        if (32'(i_item.step_count) > MAX_SUBSTEPS) begin
            cmd_in.steps = 4'(MAX_SUBSTEPS);
        end else begin
            cmd_in.steps = i_item.step_count;
        end
        case (i_item.kind)
            KIND_DEPOSIT: begin
                if (in_grid && (i_item.add_height != 16'sd0 || i_item.add_previous != 16'sd0)) begin
                    cmd_in.op = OP_DEPOSIT;
                end
            end
            KIND_STEP: begin
                if (i_item.step_count != 4'd0) begin
                    cmd_in.op = OP_STEP;
                end
            end
            KIND_READ: begin
                if (in_grid) begin
                    cmd_in.op = OP_READ;
                end
            end
            default: cmd_in.op = OP_NOP;
        endcase
    end

    always_comb begin
        n_wp  = r_wp ^ accept;
        n_rp  = r_rp ^ take;
        n_cnt = r_cnt + {1'b0, accept} - {1'b0, take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// ===== design/dwg_engine.sv =====
// ----------------------------------------------------------------------------
// dwg_engine
// Executes commands on two height banks: deposit, read, stencil sweeps,
// amplitude sum and clearing; holds one result for the output side.
// ----------------------------------------------------------------------------
module dwg_engine import dwg_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_init_clear,
    output logic    o_out_valid,
    output t_result o_out,
    input  logic    i_out_pop
);

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIDE);
    localparam int SUM_W = AW + 16;
    localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam logic [CW-1:0] X_LAST = CW'(GRID_SIDE - 1);
    localparam logic [CW-1:0] X_PEN  = CW'(GRID_SIDE - 2);

    logic signed [15:0] mem0 [CELLS];
    logic signed [15:0] mem1 [CELLS];
    logic signed [15:0] r_rd0;
    logic signed [15:0] r_rd1;

    t_eng_state         r_state, n_state;
    logic [AW:0]        r_cnt, n_cnt;
    logic [CW-1:0]      r_x, n_x, r_z, n_z;
    logic [2:0]         r_ph, n_ph;
    logic [3:0]         r_sweeps, n_sweeps;
    logic               r_sel, n_sel;
    logic               r_sleeping, n_sleeping;
    logic               r_init, n_init;
    logic signed [15:0] r_h, n_h, r_p, n_p;
    logic signed [17:0] r_acc, n_acc;
    logic signed [36:0] r_prod1, n_prod1;
    logic signed [22:0] r_next, n_next;
    logic signed [39:0] r_prod2, n_prod2;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic signed [15:0] r_height, n_height;
    t_cmd               r_cmd, n_cmd;
    logic               r_out_vld, n_out_vld;
    t_result            r_out, n_out;

    logic [AW-1:0]      a_cur, a_prev, wa;
    logic               we_cur, we_prev;
    logic signed [15:0] wd_cur, wd_prev;
    logic signed [15:0] rd_cur, rd_prev;
    logic signed [18:0] lap;
    logic signed [36:0] t1;
    logic signed [39:0] t2;
    logic signed [23:0] rs2, fin;
    logic               rim0, rim1;
    logic [CW-1:0]      xl, xr, zd, zu;

    function automatic logic [AW-1:0] addr_of(input int x, input int z);
        return AW'(z * GRID_SIDE + x);
    endfunction

    assign rd_cur       = r_sel ? r_rd1 : r_rd0;
    assign rd_prev      = r_sel ? r_rd0 : r_rd1;
    assign o_init_clear = r_init;
    assign o_out_valid  = r_out_vld;
    assign o_out        = r_out;

    always_comb begin
        xl   = (r_x == '0) ? r_x : r_x - 1'b1;
        xr   = (r_x == X_LAST) ? r_x : r_x + 1'b1;
        zd   = (r_z == '0) ? r_z : r_z - 1'b1;
        zu   = (r_z == X_LAST) ? r_z : r_z + 1'b1;
        rim0 = (r_x == '0) || (r_z == '0) || (r_x == X_LAST) || (r_z == X_LAST);
        rim1 = !rim0 && ((r_x == CW'(1)) || (r_z == CW'(1)) || (r_x == X_PEN) || (r_z == X_PEN));
        lap  = 19'(r_acc) - (19'(r_h) <<< 2);
        t1   = r_prod1 + 37'sd32768;
        t2   = r_prod2 + 40'sd32768;
        rs2  = t2[39:16];
        if (rim0) begin
            fin = 24'sd0;
        end else if (rim1) begin
            fin = (rs2 + 24'sd1) >>> 1;
        end else begin
            fin = rs2;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_x        = r_x;
        n_z        = r_z;
        n_ph       = r_ph;
        n_sweeps   = r_sweeps;
        n_sel      = r_sel;
        n_sleeping = r_sleeping;
        n_init     = r_init;
        n_h        = r_h;
        n_p        = r_p;
        n_acc      = r_acc;
        n_prod1    = r_prod1;
        n_next     = r_next;
        n_prod2    = r_prod2;
        n_sum      = r_sum;
        n_height   = r_height;
        n_cmd      = r_cmd;
        n_out_vld  = r_out_vld && !i_out_pop;
        n_out      = r_out;
        o_cmd_pop  = 1'b0;
        a_cur      = addr_of(int'(r_x), int'(r_z));
        a_prev     = a_cur;
        wa         = a_cur;
        we_cur     = 1'b0;
        we_prev    = 1'b0;
        wd_cur     = 16'sd0;
        wd_prev    = 16'sd0;
        case (r_state)
            ST_CLEAR: begin
                we_cur  = 1'b1;
                we_prev = 1'b1;
                wa      = r_cnt[AW-1:0];
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(CELLS - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                a_cur  = addr_of(int'(i_cmd.cell_x), int'(i_cmd.cell_z));
                a_prev = a_cur;
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_height  = 16'sd0;
                    case (i_cmd.op)
                        OP_DEPOSIT: n_state = ST_DEP;
                        OP_READ:    n_state = ST_RD;
                        OP_STEP: begin
                            if (r_sleeping) begin
                                n_state = ST_DONE;
                            end else begin
                                n_sweeps = i_cmd.steps;
                                n_x      = '0;
                                n_z      = '0;
                                n_ph     = 3'd0;
                                n_state  = ST_SWEEP;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_DEP: begin
                wa         = addr_of(int'(r_cmd.cell_x), int'(r_cmd.cell_z));
                we_cur     = 1'b1;
                we_prev    = 1'b1;
                wd_cur     = sat16(24'(rd_cur) + 24'(r_cmd.add_height));
                wd_prev    = sat16(24'(rd_prev) + 24'(r_cmd.add_previous));
                n_sleeping = 1'b0;
                n_state    = ST_DONE;
            end
            ST_RD: begin
                n_height = rd_cur;
                n_state  = ST_DONE;
            end
            ST_SWEEP: begin
                case (r_ph)
                    3'd1:    a_cur = addr_of(int'(xl), int'(r_z));
                    3'd2:    a_cur = addr_of(int'(xr), int'(r_z));
                    3'd3:    a_cur = addr_of(int'(r_x), int'(zd));
                    3'd4:    a_cur = addr_of(int'(r_x), int'(zu));
                    default: a_cur = addr_of(int'(r_x), int'(r_z));
                endcase
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd1) begin
                    n_h   = rd_cur;
                    n_p   = rd_prev;
                    n_acc = 18'sd0;
                end else if (r_ph != 3'd0) begin
                    n_acc = r_acc + 18'(rd_cur);
                end
                if (r_ph == 3'd5) begin
                    n_ph    = 3'd0;
                    n_state = ST_MUL1;
                end
            end
            ST_MUL1: begin
                n_prod1 = 37'($signed({1'b0, i_cfg.wave_coef}) * lap);
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_next  = (23'(r_h) <<< 1) - 23'(r_p) + 23'($signed(t1[36:16]));
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                n_prod2 = 40'(r_next * $signed({1'b0, i_cfg.damping}));
                n_state = ST_WR;
            end
            ST_WR: begin
                we_prev = 1'b1;
                wd_prev = sat16(fin);
                n_state = ST_SWEEP;
                if (r_x == X_LAST) begin
                    n_x = '0;
                    if (r_z == X_LAST) begin
                        n_z      = '0;
                        n_sel    = !r_sel;
                        n_sweeps = r_sweeps - 4'd1;
                        if (r_sweeps == 4'd1) begin
                            n_cnt   = '0;
                            n_sum   = '0;
                            n_state = ST_SUM;
                        end
                    end else begin
                        n_z = r_z + 1'b1;
                    end
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
            ST_SUM: begin
                a_cur = r_cnt[AW-1:0];
                n_cnt = r_cnt + 1'b1;
                if (r_cnt != '0) begin
                    n_sum = r_sum + SUM_W'(rd_cur[15] ? -17'(rd_cur) : 17'(rd_cur));
                end
                if (r_cnt == (AW+1)'(CELLS)) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (CMP_W'(r_sum) < CMP_W'(i_cfg.sleep_thr)) begin
                    n_sleeping = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_CLEAR;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_out_pop) begin
                    n_out_vld     = 1'b1;
                    n_out.height  = r_height;
                    n_out.asleep  = r_sleeping;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_cnt      <= '0;
            r_sel      <= 1'b0;
            r_sleeping <= 1'b1;
            r_init     <= 1'b1;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_sel      <= n_sel;
            r_sleeping <= n_sleeping;
            r_init     <= n_init;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_z      <= n_z;
        r_ph     <= n_ph;
        r_sweeps <= n_sweeps;
        r_h      <= n_h;
        r_p      <= n_p;
        r_acc    <= n_acc;
        r_prod1  <= n_prod1;
        r_next   <= n_next;
        r_prod2  <= n_prod2;
        r_sum    <= n_sum;
        r_height <= n_height;
        r_cmd    <= n_cmd;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (r_sel ? we_prev : we_cur) begin
            mem0[wa] <= r_sel ? wd_prev : wd_cur;
        end
        r_rd0 <= mem0[r_sel ? a_prev : a_cur];
    end

    always_ff @(posedge i_clk) begin
        if (r_sel ? we_cur : we_prev) begin
            mem1[wa] <= r_sel ? wd_cur : wd_prev;
        end
        r_rd1 <= mem1[r_sel ? a_cur : a_prev];
    end

endmodule

// ===== verif/damped_wave_grid_step_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// damped_wave_grid_step_tb
// Self-checking bench for the damped wave grid: deposit, step and read
// transactions are driven through the push side and each popped result is
// compared with a local model of the grid, the sleep flag and the registers.
// ----------------------------------------------------------------------------
module damped_wave_grid_step_tb;
    import dwg_pkg::*;

    localparam int SIDE  = GRID_SIDE_DEF;
    localparam int CELLS = SIDE * SIDE;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_item                 i_item = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_result               o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    damped_wave_grid_step u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // grid model
    logic signed [15:0] grid_cur [CELLS];
    logic signed [15:0] grid_prev[CELLS];
    logic               grid_asleep;
    logic [15:0]        wave_coef;
    logic [15:0]        damping;
    logic [THR_W-1:0]   sleep_thr;

    t_result pending_results[$];
    int      error_count = 0;
    bit      calm = 1'b0;
    int      pop_hold = 0;

    function automatic longint round_half_up(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic void run_sweep();
        logic signed [15:0] fresh[CELLS];
        longint k, d, h, lap, nx;
        int xl, xr, zd, zu, rim;
        k = (wave_coef > 16'd32768) ? 32768 : longint'(wave_coef);
        d = longint'(damping);
        for (int z = 0; z < SIDE; z++) begin
            for (int x = 0; x < SIDE; x++) begin
                xl = (x > 0) ? x - 1 : 0;
                xr = (x < SIDE - 1) ? x + 1 : SIDE - 1;
                zd = (z > 0) ? z - 1 : 0;
                zu = (z < SIDE - 1) ? z + 1 : SIDE - 1;
                h = grid_cur[z*SIDE+x];
                lap = longint'(grid_cur[z*SIDE+xl]) + grid_cur[z*SIDE+xr]
                    + grid_cur[zd*SIDE+x] + grid_cur[zu*SIDE+x] - 4 * h;
                nx = 2 * h - grid_prev[z*SIDE+x] + round_half_up(k * lap, 16);
                nx = round_half_up(nx * d, 16);
                rim = x;
                if (z < rim) rim = z;
                if (SIDE - 1 - x < rim) rim = SIDE - 1 - x;
                if (SIDE - 1 - z < rim) rim = SIDE - 1 - z;
                if (rim == 0) nx = 0;
                else if (rim == 1) nx = round_half_up(nx, 1);
                fresh[z*SIDE+x] = clip16(nx);
            end
        end
        for (int i = 0; i < CELLS; i++) begin
            grid_prev[i] = grid_cur[i];
            grid_cur[i]  = fresh[i];
        end
    endfunction

    function automatic t_result apply_item(t_item it);
        t_result r;
        int idx, n;
        longint total;
        r = '0;
        idx = it.cell_z * SIDE + it.cell_x;
        case (it.kind)
            KIND_DEPOSIT: begin
                if (it.add_height != 0 || it.add_previous != 0) begin
                    grid_cur[idx]  = clip16(longint'(grid_cur[idx]) + it.add_height);
                    grid_prev[idx] = clip16(longint'(grid_prev[idx]) + it.add_previous);
                    grid_asleep = 1'b0;
                end
            end
            KIND_STEP: begin
                if (!grid_asleep && it.step_count != 0) begin
                    n = (it.step_count > MAX_SUBSTEPS_DEF) ? MAX_SUBSTEPS_DEF
                                                           : it.step_count;
                    for (int s = 0; s < n; s++) run_sweep();
                    total = 0;
                    for (int i = 0; i < CELLS; i++)
                        total += (grid_cur[i] < 0) ? -longint'(grid_cur[i])
                                                   : longint'(grid_cur[i]);
                    if (total < longint'(sleep_thr)) begin
                        for (int i = 0; i < CELLS; i++) begin
                            grid_cur[i]  = '0;
                            grid_prev[i] = '0;
                        end
                        grid_asleep = 1'b1;
                    end
                end
            end
            KIND_READ: begin
                if (!grid_asleep) r.height = grid_cur[idx];
            end
            default: ;
        endcase
        r.asleep = grid_asleep;
        return r;
    endfunction

    // result side: random pop stalls outside the calm phase, checked on every popped result
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result height=%0d asleep=%0b", $time,
                         o_result.height, o_result.asleep);
                error_count++;
            end else begin
                t_result want;
                want = pending_results.pop_front();
                if (o_result.height !== want.height) begin
                    $display("%0t: height expected %0d actual %0d", $time,
                             want.height, o_result.height);
                    error_count++;
                end
                if (o_result.asleep !== want.asleep) begin
                    $display("%0t: asleep expected %0b actual %0b", $time,
                             want.asleep, o_result.asleep);
                    error_count++;
                end
            end
        end
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            pop_hold <= $urandom_range(1, 14) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic send_item(t_item it);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        pending_results.push_back(apply_item(it));
        if (!calm && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            REG_WAVE_COEF: wave_coef = value[15:0];
            REG_DAMPING:   damping   = value[15:0];
            REG_SLEEP_THR: sleep_thr = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    function automatic t_item make_item(logic [1:0] kind, int x, int z,
                                        int ah, int ap, int steps);
        t_item it;
        it.kind         = kind;
        it.cell_x       = x[4:0];
        it.cell_z       = z[4:0];
        it.add_height   = ah[15:0];
        it.add_previous = ap[15:0];
        it.step_count   = steps[3:0];
        return it;
    endfunction

    function automatic t_item random_item();
        t_item       it;
        logic [63:0] raw;
        int          pick;
        raw = {$urandom, $urandom};
        it = raw[$bits(t_item)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            it.kind = KIND_DEPOSIT;
            if ($urandom_range(0, 9) == 0) begin
                it.add_height   = '0;
                it.add_previous = '0;
            end
        end else if (pick < 82) begin
            it.kind = KIND_READ;
        end else if (pick < 96) begin
            it.kind = KIND_STEP;
            pick = $urandom_range(0, 39);
            if (pick == 0) it.step_count = 4'($urandom_range(9, 15));
            else if (pick < 4) it.step_count = '0;
            else it.step_count = 4'($urandom_range(1, 2));
        end else begin
            it.kind = KIND_NONE;
        end
        return it;
    endfunction

    task automatic test_sleeping_field();
        send_item(make_item(KIND_READ, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_STEP, 0, 0, 0, 0, 1));
        send_item(make_item(KIND_DEPOSIT, 5, 5, 0, 0, 0));
        send_item(make_item(KIND_NONE, 31, 31, -1, -1, 15));
        send_item(make_item(KIND_READ, 5, 5, 0, 0, 0));
    endtask

    task automatic test_deposit_read();
        send_item(make_item(KIND_DEPOSIT, 16, 16, 32767, 32767, 0));
        send_item(make_item(KIND_DEPOSIT, 16, 16, 32767, -32768, 0));
        send_item(make_item(KIND_READ, 16, 16, 0, 0, 0));
        send_item(make_item(KIND_DEPOSIT, 0, 0, -32768, 0, 0));
        send_item(make_item(KIND_DEPOSIT, 0, 0, -32768, 0, 0));
        send_item(make_item(KIND_DEPOSIT, 31, 31, 1, 0, 0));
        send_item(make_item(KIND_DEPOSIT, 31, 0, 0, -1, 0));
        send_item(make_item(KIND_READ, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_READ, 31, 31, 0, 0, 0));
        send_item(make_item(KIND_NONE, 16, 16, 0, 0, 0));
    endtask

    task automatic test_steps();
        send_item(make_item(KIND_STEP, 0, 0, 0, 0, 0));
        send_item(make_item(KIND_STEP, 0, 0, 0, 0, 1));
        send_item(make_item(KIND_READ, 16, 17, 0, 0, 0));
        send_item(make_item(KIND_STEP, 0, 0, 0, 0, 15));
        send_item(make_item(KIND_READ, 16, 16, 0, 0, 0));
        send_item(make_item(KIND_READ, 1, 16, 0, 0, 0));
    endtask

    task automatic test_registers();
        write_reg(REG_WAVE_COEF, 26'd65535);
        write_reg(REG_DAMPING, 26'd65535);
        write_reg(REG_SLEEP_THR, 26'd0);
        write_reg(REG_NONE, 26'h3FFFFFF);
        send_item(make_item(KIND_DEPOSIT, 10, 12, 20000, -5000, 0));
        send_item(make_item(KIND_STEP, 0, 0, 0, 0, 2));
        send_item(make_item(KIND_READ, 10, 11, 0, 0, 0));
        write_reg(REG_WAVE_COEF, 26'd0);
        write_reg(REG_DAMPING, 26'd0);
        send_item(make_item(KIND_STEP, 0, 0, 0, 0, 1));
        write_reg(REG_SLEEP_THR, 26'd33554432);
        write_reg(REG_DAMPING, 26'd65209);
        write_reg(REG_WAVE_COEF, 26'd32768);
        send_item(make_item(KIND_DEPOSIT, 3, 4, 4096, 0, 0));
        send_item(make_item(KIND_STEP, 0, 0, 0, 0, 1));
        write_reg(REG_SLEEP_THR, 26'd41);
        write_reg(REG_WAVE_COEF, 26'd16384);
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            send_item(random_item());
            if (n == count / 2) drain();
        end
    endtask

    task automatic test_calm(int count);
        drain();
        write_reg(REG_WAVE_COEF, 26'd24000);
        write_reg(REG_DAMPING, 26'd60000);
        write_reg(REG_SLEEP_THR, 26'd500);
        calm = 1'b1;
        for (int n = 0; n < count; n++) send_item(random_item());
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            grid_cur[i]  = '0;
            grid_prev[i] = '0;
        end
        grid_asleep = 1'b1;
        wave_coef   = WAVE_COEF_RST;
        damping     = DAMPING_RST;
        sleep_thr   = SLEEP_THR_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_sleeping_field();
        test_deposit_read();
        test_steps();
        test_registers();
        test_random(60);
        test_calm(20);
        drain();
        if (error_count == 0) begin
            $display("damped_wave_grid_step_tb: done, clean");
        end else begin
            $display("damped_wave_grid_step_tb: done, errors");
        end
        $finish;
    end

    // every transaction a full eight-sweep step stays well under this
    initial begin
        #500_000_000;
        $display("damped_wave_grid_step_tb: done, errors");
        $finish;
    end

endmodule
